// ===== sv/tcst_pkg.sv =====
// Shared widths, flag positions, state and event codes and entry layouts of the TCP tracker.
package tcst_pkg;

    localparam int FLOW_SLOT_W = 10;
    localparam int FLAGS_W     = 8;
    localparam int SEQ_W       = 32;
    localparam int LEN_W       = 16;
    localparam int TIME_W      = 64;
    localparam int STATE_W     = 4;
    localparam int INV_W       = 16;
    localparam int EVENT_W     = 3;
    localparam int PKT_W       = 32;
    localparam int BYTE_W      = 64;

    // Bit positions in the TCP flag byte
    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_ACK = 4;

    // Connection state codes
    localparam logic [STATE_W-1:0] ST_NEW         = 4'd0;
    localparam logic [STATE_W-1:0] ST_SYN_SENT    = 4'd1;
    localparam logic [STATE_W-1:0] ST_SYN_RECV    = 4'd2;
    localparam logic [STATE_W-1:0] ST_ESTABLISHED = 4'd3;
    localparam logic [STATE_W-1:0] ST_FIN_WAIT1   = 4'd4;
    localparam logic [STATE_W-1:0] ST_FIN_WAIT2   = 4'd5;
    localparam logic [STATE_W-1:0] ST_CLOSE_WAIT  = 4'd6;
    localparam logic [STATE_W-1:0] ST_CLOSING     = 4'd7;
    localparam logic [STATE_W-1:0] ST_LAST_ACK    = 4'd8;
    localparam logic [STATE_W-1:0] ST_TIME_WAIT   = 4'd9;
    localparam logic [STATE_W-1:0] ST_CLOSED      = 4'd10;
    localparam logic [STATE_W-1:0] ST_INVALID     = 4'd11;

    // Statistics event codes
    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_NEW     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_EST     = 3'd2;
    localparam logic [EVENT_W-1:0] EV_CLOSED  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_INVALID = 3'd4;

    // Part of an entry that decides the result
    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [INV_W-1:0]   inv_count;
    } ctrl_t;

    // Sequence numbers, times and counters of an entry
    typedef struct packed {
        logic [SEQ_W-1:0]  orig_seq;
        logic [SEQ_W-1:0]  reply_seq;
        logic [SEQ_W-1:0]  reply_ack;
        logic [TIME_W-1:0] created;
        logic [TIME_W-1:0] last_seen;
        logic [PKT_W-1:0]  pkt_reply;
        logic [PKT_W-1:0]  pkt_orig;
        logic [BYTE_W-1:0] octets_reply;
        logic [BYTE_W-1:0] octets_orig;
    } flow_data_t;

endpackage

// ===== sv/tcst_if.sv =====
// Segment and result channel interfaces of the TCP tracker.
interface tcst_seg_if;
    logic                                valid;
    logic                                ready;
    logic [tcst_pkg::FLOW_SLOT_W-1:0]    flow_slot;
    logic                                entry_exists;
    logic [tcst_pkg::FLAGS_W-1:0]        flag_bits;
    logic [tcst_pkg::SEQ_W-1:0]          seq_number;
    logic [tcst_pkg::SEQ_W-1:0]          ack_number;
    logic [tcst_pkg::LEN_W-1:0]          packet_length;
    logic [tcst_pkg::TIME_W-1:0]         timestamp_ns;
    logic                                from_originator;

    modport source (
        output valid, flow_slot, entry_exists, flag_bits, seq_number, ack_number,
               packet_length, timestamp_ns, from_originator,
        input  ready
    );
    modport sink (
        input  valid, flow_slot, entry_exists, flag_bits, seq_number, ack_number,
               packet_length, timestamp_ns, from_originator,
        output ready
    );
endinterface

interface tcst_res_if;
    logic                            valid;
    logic                            ready;
    logic                            verdict;
    logic [tcst_pkg::STATE_W-1:0]    connection_state;
    logic [tcst_pkg::INV_W-1:0]      invalid_events;
    logic [tcst_pkg::EVENT_W-1:0]    stat_event;

    modport source (
        output valid, verdict, connection_state, invalid_events, stat_event,
        input  ready
    );
    modport sink (
        input  valid, verdict, connection_state, invalid_events, stat_event,
        output ready
    );
endinterface

// ===== sv/tcst_ram.sv =====
// Generic simple dual-port RAM with registered read, read-before-write.
module tcst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/tcp_connection_state_tracker_unit.sv =====
// Per-flow TCP connection tracker over a slot table held in two RAMs.
//
// Channels: seg (sink) takes one parsed TCP segment per word; res (source)
// gives one result word per segment: verdict, state after update, invalid
// count and statistics event. cfg_wr_en/cfg_wr_data write the invalid drop
// threshold; write it only while no segment is in flight.
// A segment accepted into the read stage has its result word registered into
// the output register when that stage advances. Throughput: one segment per
// cycle while the output is not stalled. The entry is read at accept and
// written back as the segment leaves the read stage; a forwarding register
// covers a segment for the same slot that reads on the edge of that write.
// Per-slot state lives in a 20-bit control RAM (state, invalid count) and a
// 416-bit data RAM (sequence numbers, times, counters), FLOW_SLOTS deep.
// Reset: threshold returns to 5, pipeline and output emptied; the RAMs are
// not cleared, and a slot must be created (entry_exists low) before a hit.
// Stall: with the result held, one more segment waits in the read stage;
// seg.ready then drops until res.ready frees the output register.
module tcp_connection_state_tracker_unit #(
    parameter int FLOW_SLOTS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [tcst_pkg::INV_W-1:0] cfg_wr_data,
    tcst_seg_if.sink                   seg,
    tcst_res_if.source                 res
);

    localparam int ADDR_W = FLOW_SLOTS > 1 ? $clog2(FLOW_SLOTS) : 1;
    localparam int CTRL_W = $bits(tcst_pkg::ctrl_t);
    localparam int DATA_W = $bits(tcst_pkg::flow_data_t);

    logic [tcst_pkg::INV_W-1:0]       thr_reg;

    logic                             seg_fire;
    logic [tcst_pkg::FLOW_SLOT_W-1:0] slot_mod;
    logic [ADDR_W-1:0]                rd_addr;

    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic                             s1_advance;
    logic [ADDR_W-1:0]                s1_addr_reg;
    logic                             s1_exists_reg;
    logic [tcst_pkg::FLAGS_W-1:0]     s1_flags_reg;
    logic [tcst_pkg::SEQ_W-1:0]       s1_seq_reg;
    logic [tcst_pkg::SEQ_W-1:0]       s1_ack_reg;
    logic [tcst_pkg::LEN_W-1:0]       s1_len_reg;
    logic [tcst_pkg::TIME_W-1:0]      s1_time_reg;
    logic                             s1_orig_reg;

    tcst_pkg::ctrl_t                  ctrl_rdata;
    tcst_pkg::flow_data_t             data_rdata;
    tcst_pkg::ctrl_t                  cur_ctrl;
    tcst_pkg::flow_data_t             cur_data;
    tcst_pkg::ctrl_t                  new_ctrl;
    tcst_pkg::flow_data_t             new_data;
    logic                             fwd_hit;

    logic                             fwd_valid_reg;
    logic [ADDR_W-1:0]                fwd_addr_reg;
    tcst_pkg::ctrl_t                  fwd_ctrl_reg;
    tcst_pkg::flow_data_t             fwd_data_reg;

    logic                             drop;
    logic [tcst_pkg::EVENT_W-1:0]     ev;
    logic                             syn;
    logic                             ackf;
    logic                             fin;
    logic                             rstf;

    logic                             res_valid_reg;
    logic                             res_valid_next;
    logic                             res_verdict_reg;
    logic [tcst_pkg::STATE_W-1:0]     res_state_reg;
    logic [tcst_pkg::INV_W-1:0]       res_inv_reg;
    logic [tcst_pkg::EVENT_W-1:0]     res_event_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= tcst_pkg::INV_W'(5);
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Fold the slot into the table by restoring subtraction of shifted depths
    always_comb
    begin
        slot_mod = seg.flow_slot;
        for (int k = tcst_pkg::FLOW_SLOT_W - 1; k >= 0; k--)
        begin
            if ((FLOW_SLOTS << k) < (1 << tcst_pkg::FLOW_SLOT_W))
            begin
                if (32'(slot_mod) >= 32'(FLOW_SLOTS << k))
                begin
                    slot_mod = slot_mod - tcst_pkg::FLOW_SLOT_W'(FLOW_SLOTS << k);
                end
            end
        end
    end

    assign rd_addr    = ADDR_W'(slot_mod);
    assign s1_advance = s1_valid_reg && (!res_valid_reg || res.ready);
    assign seg.ready  = !s1_valid_reg || s1_advance;
    assign seg_fire   = seg.valid && seg.ready;

    assign s1_valid_next  = seg_fire || (s1_valid_reg && !s1_advance);
    assign res_valid_next = s1_advance || (res_valid_reg && !res.ready);

    tcst_ram #(
        .WIDTH (CTRL_W),
        .DEPTH (FLOW_SLOTS)
    ) u_ctrl_ram (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_addr_reg),
        .wdata (new_ctrl),
        .re    (seg_fire),
        .raddr (rd_addr),
        .rdata (ctrl_rdata)
    );

    tcst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (FLOW_SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_addr_reg),
        .wdata (new_data),
        .re    (seg_fire),
        .raddr (rd_addr),
        .rdata (data_rdata)
    );

    // Valid flags of the read stage (which holds the segment while its entry comes out of the RAMs), bypass and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (s1_advance)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_fire)
        begin
            s1_addr_reg   <= rd_addr;
            s1_exists_reg <= seg.entry_exists;
            s1_flags_reg  <= seg.flag_bits;
            s1_seq_reg    <= seg.seq_number;
            s1_ack_reg    <= seg.ack_number;
            s1_len_reg    <= seg.packet_length;
            s1_time_reg   <= seg.timestamp_ns;
            s1_orig_reg   <= seg.from_originator;
        end
        if (s1_advance)
        begin
            fwd_addr_reg    <= s1_addr_reg;
            fwd_ctrl_reg    <= new_ctrl;
            fwd_data_reg    <= new_data;
            res_verdict_reg <= drop;
            res_state_reg   <= new_ctrl.state;
            res_inv_reg     <= new_ctrl.inv_count;
            res_event_reg   <= ev;
        end
    end

    // The last write may share the edge of this read; take it from the bypass
    assign fwd_hit  = fwd_valid_reg && (fwd_addr_reg == s1_addr_reg);
    assign cur_ctrl = fwd_hit ? fwd_ctrl_reg : ctrl_rdata;
    assign cur_data = fwd_hit ? fwd_data_reg : data_rdata;

    assign syn  = s1_flags_reg[tcst_pkg::FLAG_SYN];
    assign ackf = s1_flags_reg[tcst_pkg::FLAG_ACK];
    assign fin  = s1_flags_reg[tcst_pkg::FLAG_FIN];
    assign rstf = s1_flags_reg[tcst_pkg::FLAG_RST];

    // Update the entry and decide the verdict
    always_comb
    begin
        new_ctrl = cur_ctrl;
        new_data = cur_data;
        drop     = 1'b0;
        ev       = tcst_pkg::EV_NONE;
        if (!s1_exists_reg)
        begin
            new_data           = '0;
            new_data.orig_seq  = s1_seq_reg;
            new_data.created   = s1_time_reg;
            new_data.last_seen = s1_time_reg;
            if (syn && !ackf)
            begin
                new_ctrl.state     = tcst_pkg::ST_SYN_SENT;
                new_ctrl.inv_count = '0;
            end
            else
            begin
                new_ctrl.state     = tcst_pkg::ST_INVALID;
                new_ctrl.inv_count = tcst_pkg::INV_W'(1);
            end
        end
        else
        begin
            if (s1_orig_reg)
            begin
                new_data.pkt_orig    = cur_data.pkt_orig + tcst_pkg::PKT_W'(1);
                new_data.octets_orig = cur_data.octets_orig + tcst_pkg::BYTE_W'(s1_len_reg);
            end
            else
            begin
                new_data.pkt_reply    = cur_data.pkt_reply + tcst_pkg::PKT_W'(1);
                new_data.octets_reply = cur_data.octets_reply + tcst_pkg::BYTE_W'(s1_len_reg);
            end
            new_data.last_seen = s1_time_reg;

            if (rstf)
            begin
                new_ctrl.state = tcst_pkg::ST_CLOSED;
                ev             = tcst_pkg::EV_CLOSED;
            end
            else
            begin
                unique case (cur_ctrl.state)
                    tcst_pkg::ST_NEW:
                    begin
                        if (syn && !ackf)
                        begin
                            new_ctrl.state    = tcst_pkg::ST_SYN_SENT;
                            new_data.orig_seq = s1_seq_reg;
                            ev                = tcst_pkg::EV_NEW;
                        end
                        else
                        begin
                            new_ctrl.state     = tcst_pkg::ST_INVALID;
                            new_ctrl.inv_count = cur_ctrl.inv_count + tcst_pkg::INV_W'(1);
                            ev                 = tcst_pkg::EV_INVALID;
                            drop               = 1'b1;
                        end
                    end
                    tcst_pkg::ST_SYN_SENT:
                    begin
                        if (syn)
                        begin
                            new_ctrl.state = tcst_pkg::ST_SYN_RECV;
                            if (ackf)
                            begin
                                new_data.reply_seq = s1_seq_reg;
                                new_data.reply_ack = s1_ack_reg;
                            end
                        end
                        else
                        begin
                            new_ctrl.inv_count = cur_ctrl.inv_count + tcst_pkg::INV_W'(1);
                            ev                 = tcst_pkg::EV_INVALID;
                        end
                    end
                    tcst_pkg::ST_SYN_RECV:
                    begin
                        if (ackf)
                        begin
                            new_ctrl.state = tcst_pkg::ST_ESTABLISHED;
                            ev             = tcst_pkg::EV_EST;
                        end
                    end
                    tcst_pkg::ST_ESTABLISHED:
                    begin
                        if (fin)
                        begin
                            new_ctrl.state = s1_orig_reg ? tcst_pkg::ST_FIN_WAIT1
                                                         : tcst_pkg::ST_CLOSE_WAIT;
                        end
                    end
                    tcst_pkg::ST_FIN_WAIT1:
                    begin
                        if (ackf)
                        begin
                            new_ctrl.state = tcst_pkg::ST_FIN_WAIT2;
                        end
                    end
                    tcst_pkg::ST_FIN_WAIT2:
                    begin
                        if (fin)
                        begin
                            new_ctrl.state = tcst_pkg::ST_TIME_WAIT;
                        end
                    end
                    tcst_pkg::ST_CLOSE_WAIT:
                    begin
                        if (fin)
                        begin
                            new_ctrl.state = tcst_pkg::ST_LAST_ACK;
                        end
                    end
                    tcst_pkg::ST_LAST_ACK:
                    begin
                        if (ackf)
                        begin
                            new_ctrl.state = tcst_pkg::ST_CLOSED;
                            ev             = tcst_pkg::EV_CLOSED;
                        end
                    end
                    // Closing, time-wait, closed and invalid entries move only on RST
                    default:
                    begin
                    end
                endcase
            end

            if ((new_ctrl.state == tcst_pkg::ST_INVALID) && (new_ctrl.inv_count > thr_reg))
            begin
                drop = 1'b1;
            end
        end
    end

    assign res.valid            = res_valid_reg;
    assign res.verdict          = res_verdict_reg;
    assign res.connection_state = res_state_reg;
    assign res.invalid_events   = res_inv_reg;
    assign res.stat_event       = res_event_reg;

    // A created entry always passes with no event
    a_miss_pass: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && !s1_exists_reg |=>
            res_valid_reg && !res_verdict_reg && (res_event_reg == tcst_pkg::EV_NONE))
        else $error("created entry did not pass with no event");

    a_miss_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && !s1_exists_reg |=>
            ((res_state_reg == tcst_pkg::ST_SYN_SENT) && (res_inv_reg == '0)) ||
            ((res_state_reg == tcst_pkg::ST_INVALID) && (res_inv_reg == tcst_pkg::INV_W'(1))))
        else $error("created entry has wrong state or invalid count");

    a_rst_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_exists_reg && rstf |=>
            (res_state_reg == tcst_pkg::ST_CLOSED) && (res_event_reg == tcst_pkg::EV_CLOSED))
        else $error("reset segment did not close the connection");

    a_bypass_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> fwd_valid_reg && (fwd_addr_reg == $past(s1_addr_reg)))
        else $error("bypass register lost the last written slot");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !seg.ready |-> s1_valid_reg && res_valid_reg && !res.ready)
        else $error("segment refused without an output stall");

endmodule
